// ===== hdl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, codes and types for the cache core and its cell chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int CAPACITY_MAX = 16;
   localparam int KEY_BYTES    = 8;
   localparam int VALUE_BYTES  = 8;

   localparam int FIELD_W = 64;
   localparam int FUNC_W  = 2;
   localparam int CAP_W   = 5;
   localparam int KEY_W   = 8 * KEY_BYTES;
   localparam int VAL_W   = 8 * VALUE_BYTES;
   localparam int CNT_W   = $clog2(CAPACITY_MAX + 1);
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET = 2'd0,
      FUNC_PUT = 2'd1,
      FUNC_DEL = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_PREV = 2'd1,
      CELL_FROM_NEXT = 2'd2,
      CELL_LOAD      = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic        capture;
      cell_op_type op;
   } cell_ctl_type;

endpackage

// ===== hdl/lkvc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one get, put or delete request.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [FIELD_W-1:0] key;
   logic [FIELD_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);

endinterface

// ===== hdl/lkvc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the status and read value of one request.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if import lkvc_pkg::*; ();

   logic               valid;
   logic               ready;
   logic               status;
   logic [FIELD_W-1:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);

endinterface

// ===== hdl/lkvc_csr_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the capacity register write data.
// ----------------------------------------------------------------------------
interface lkvc_csr_if import lkvc_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// Cache cell
// One entry of the recency-ordered chain: holds key and value, matches the
// request key and takes its next contents from either neighbor or the front.
// ----------------------------------------------------------------------------
module lkvc_cell import lkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [KEY_W-1:0] cmp_key,
   input  entry_type        prev_entry,
   input  entry_type        next_entry,
   input  entry_type        load_entry,
   input  logic             seen_in,
   input  logic [VAL_W-1:0] hit_value_in,
   output entry_type        entry_out,
   output logic             seen_out,
   output logic [VAL_W-1:0] hit_value_out
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             match_ff, match_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_FROM_PREV: begin
            valid_in = prev_entry.valid;
            key_in   = prev_entry.key;
            value_in = prev_entry.value;
         end
         CELL_FROM_NEXT: begin
            valid_in = next_entry.valid;
            key_in   = next_entry.key;
            value_in = next_entry.value;
         end
         CELL_LOAD: begin
            valid_in = load_entry.valid;
            key_in   = load_entry.key;
            value_in = load_entry.value;
         end
         default: begin
         end
      endcase
   end

   assign match_in = ctl.capture ? (valid_ff && (key_ff == cmp_key)) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.key   = key_ff;
   assign entry_out.value = value_ff;
   assign seen_out        = seen_in | match_ff;
   assign hit_value_out   = hit_value_in | (value_ff & {VAL_W{match_ff}});

endmodule

// ===== hdl/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Recency-ordered chain of cells: front cell is most recent. Get and put hits
// move the entry to the front, put misses insert at the front and evict the
// tail when full, deletes close the gap by pulling the tail up.
// ----------------------------------------------------------------------------
// An accepted request is registered and moves the core to EXEC; its response
// is registered when the cell chain shifts. No new request is taken until the
// core is back in IDLE; the key match runs in the accept cycle and the chain
// shifts in EXEC. A waiting response stalls EXEC until it is taken.
// Reset clears all entry valid bits, the entry count and the match flags, and
// sets capacity to 16; requests are taken right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core import lkvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lkvc_req_if.sink    req_if,
   lkvc_rsp_if.source  rsp_if,
   lkvc_csr_if.sink    csr_if
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               status_ff, status_in;
   logic [FIELD_W-1:0] read_value_ff, read_value_in;

   logic               req_fire;
   logic               go;
   logic               hit;
   logic               is_get, is_put, is_del;
   logic               move_front, insert, remove;
   logic               evict;
   logic [CMP_W-1:0]   cap_ext, eff_cap;
   logic [CNT_W-1:0]   shift_limit;
   logic [VAL_W-1:0]   hit_value;
   entry_type          load_entry;

   entry_type          cur [CAPACITY_MAX];
   logic               seen [CAPACITY_MAX+1];
   logic [VAL_W-1:0]   hval [CAPACITY_MAX+1];
   logic [CAPACITY_MAX-1:0] valid_vec;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign go           = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   assign csr_if.ready = 1'b1;

   assign is_get = (func_ff == FUNC_GET);
   assign is_put = (func_ff == FUNC_PUT);
   assign is_del = (func_ff == FUNC_DEL);

   assign seen[0]   = 1'b0;
   assign hval[0]   = '0;
   assign hit       = seen[CAPACITY_MAX];
   assign hit_value = hval[CAPACITY_MAX];

   assign move_front = go && hit && (is_get || is_put);
   assign insert     = go && !hit && is_put;
   assign remove     = go && hit && is_del;

   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(CAPACITY_MAX)) begin
         eff_cap = CMP_W'(CAPACITY_MAX);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict       = (CMP_W'(count_ff) >= eff_cap);
   assign shift_limit = evict ? (count_ff - CNT_W'(1)) : count_ff;

   assign load_entry.valid = 1'b1;
   assign load_entry.key   = key_ff;
   assign load_entry.value = is_put ? value_ff : hit_value;

   for (genvar i = 0; i < CAPACITY_MAX; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    prev_entry;
      entry_type    next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = '0;
      end else begin : g_mid_prev
         assign prev_entry = cur[i-1];
      end

      if (i == CAPACITY_MAX - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid_next
         assign next_entry = cur[i+1];
      end

      always_comb begin
         ctl.capture = req_fire;
         ctl.op      = CELL_HOLD;
         if (move_front) begin
            if (i == 0) begin
               ctl.op = CELL_LOAD;
            end else if (!seen[i]) begin
               ctl.op = CELL_FROM_PREV;
            end
         end else if (insert) begin
            if (i == 0) begin
               ctl.op = CELL_LOAD;
            end else if (CNT_W'(i) <= shift_limit) begin
               ctl.op = CELL_FROM_PREV;
            end
         end else if (remove) begin
            if (seen[i+1]) begin
               ctl.op = CELL_FROM_NEXT;
            end
         end
      end

      lkvc_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .cmp_key       (req_if.key[KEY_W-1:0]),
         .prev_entry    (prev_entry),
         .next_entry    (next_entry),
         .load_entry    (load_entry),
         .seen_in       (seen[i]),
         .hit_value_in  (hval[i]),
         .entry_out     (cur[i]),
         .seen_out      (seen[i+1]),
         .hit_value_out (hval[i+1])
      );

      assign valid_vec[i] = cur[i].valid;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      capacity_in   = capacity_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      read_value_in = read_value_ff;

      if (csr_if.valid && csr_if.ready) begin
         capacity_in = csr_if.data;
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_if.func;
               key_in   = req_if.key[KEY_W-1:0];
               value_in = req_if.value[VAL_W-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               rsp_valid_in  = 1'b1;
               status_in     = STATUS_MISS;
               read_value_in = '0;
               if (is_put) begin
                  status_in = STATUS_OK;
               end else if ((is_get || is_del) && hit) begin
                  status_in = STATUS_OK;
               end
               if (is_get && hit) begin
                  read_value_in = FIELD_W'(hit_value);
               end
               if (insert && !evict) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (remove) begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.read_value = read_value_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY_MAX)
      else $error("entry count above capacity limit");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("entry count differs from number of valid cells");

   a_front_packed: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> cur[0].valid)
      else $error("valid entries not packed at the front of the chain");

   a_hit_needs_entry: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && seen[CAPACITY_MAX]) |-> (count_ff != '0))
      else $error("key match flagged with no entry held");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside the execute cycle");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

endmodule
